// ----- src/ctdc_pkg.sv -----
`default_nettype none

package ctdc_pkg;

  localparam int LEVEL_W    = 16;
  localparam int MATCH_W    = 4;
  localparam int CENTROID_W = 11;
  localparam int FRAC_W     = 8;
  localparam int DW         = 19;
  localparam int COLOUR_W   = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COLOUR_W-1:0] COLOUR_RED   = 2'd0;
  localparam logic [COLOUR_W-1:0] COLOUR_GREEN = 2'd1;
  localparam logic [COLOUR_W-1:0] COLOUR_BLUE  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_COLOUR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELATIVE_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RELATIVE_HIGH = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DARK_LIMIT    = 2'd3;

  localparam logic [COLOUR_W-1:0] TARGET_COLOUR_RESET = COLOUR_RED;
  localparam logic [LEVEL_W-1:0]  RELATIVE_LOW_RESET  = 16'd40;
  localparam logic [LEVEL_W-1:0]  RELATIVE_HIGH_RESET = 16'd10000;
  localparam logic [LEVEL_W-1:0]  DARK_LIMIT_RESET    = 16'd100;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic               row_end;
  } reading_t;

  typedef struct packed {
    logic                  detected;
    logic [MATCH_W-1:0]    match_count;
    logic [CENTROID_W-1:0] centroid;
    logic                  found;
    logic                  row_done;
  } result_t;

endpackage

`default_nettype wire

// ----- src/ctdc_in_if.sv -----
`default_nettype none

interface ctdc_in_if;
  logic               valid;
  logic               ready;
  ctdc_pkg::reading_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/ctdc_out_if.sv -----
`default_nettype none

interface ctdc_out_if;
  logic              valid;
  logic              ready;
  ctdc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/ctdc_alu.sv -----
`default_nettype none

module ctdc_alu (
  input  wire logic [ctdc_pkg::DW-1:0] a,
  input  wire logic [ctdc_pkg::DW-1:0] b,
  input  wire logic                    sub,
  output logic      [ctdc_pkg::DW-1:0] y
);
  import ctdc_pkg::*;

  logic [DW-1:0] b_op;

  // two's complement add or subtract, bit DW-1 is the sign
  assign b_op = sub ? ~b : b;
  assign y    = a + b_op + DW'(sub);

endmodule

`default_nettype wire

// ----- src/colour_tape_detect_centroid.sv -----
`default_nettype none

// Colour tape detector for one row of SENSORS colour sensors. A request is one RGB
// reading, sensors in order from index 0, and each request gives one result with the
// detected flag and the running match count; the closing reading (row_end set, or
// index SENSORS-1) also gives found and the mean matching index with 8 fractional
// bits. Classification and division run through one shared 19-bit add/subtract unit
// under a small sequencer, and the block takes no new reading while one is in work.
// A closing reading with at least one match adds a restoring division of SW+8 steps,
// one quotient bit per cycle. A finished result waits in an output register, so the
// next reading can be taken while it is still pending; the following result waits
// for it to be taken.
module colour_tape_detect_centroid #(
  parameter int SENSORS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ctdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ctdc_pkg::CFG_DATA_W-1:0]   cfg_data,
  ctdc_in_if.sink                                reading,
  ctdc_out_if.source                             result
);
  import ctdc_pkg::*;

  localparam int IW  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int SWR = $clog2(SENSORS * (SENSORS - 1) / 2 + 1);
  localparam int SW  = (SWR > 0) ? SWR : 1;
  localparam int CW  = $clog2(SENSORS + 1);
  localparam int NW  = SW + FRAC_W;
  localparam int STW = $clog2(NW);

  localparam logic [IW-1:0] LAST_INDEX = IW'(SENSORS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CLS  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [STW-1:0] STEP_DIFF1 = STW'(0);
  localparam logic [STW-1:0] STEP_LOW1  = STW'(1);
  localparam logic [STW-1:0] STEP_HIGH1 = STW'(2);
  localparam logic [STW-1:0] STEP_DIFF2 = STW'(3);
  localparam logic [STW-1:0] STEP_LOW2  = STW'(4);
  localparam logic [STW-1:0] STEP_HIGH2 = STW'(5);
  localparam logic [STW-1:0] STEP_DIV_LAST = STW'(NW - 1);

  logic [1:0]          state;
  logic [STW-1:0]      step;

  logic [COLOUR_W-1:0] target_colour;
  logic [LEVEL_W-1:0]  relative_low;
  logic [LEVEL_W-1:0]  relative_high;
  logic [LEVEL_W-1:0]  dark_limit;

  logic [IW-1:0]       sensor_index;
  logic [SW-1:0]       index_sum;
  logic [CW-1:0]       hit_count;

  logic [LEVEL_W-1:0]  red;
  logic [LEVEL_W-1:0]  green;
  logic [LEVEL_W-1:0]  blue;
  logic                last;
  logic [LEVEL_W-1:0]  diff;
  logic [DW-1:0]       acc;
  logic                ok;
  logic                hit;
  logic [NW-1:0]       quo;
  logic [CW-1:0]       rem;

  logic                out_valid;
  result_t             out_data;

  logic [DW-1:0]       alu_a;
  logic [DW-1:0]       alu_b;
  logic                alu_sub;
  logic [DW-1:0]       alu_y;
  logic                neg;

  logic [LEVEL_W-1:0]  tgt;
  logic [LEVEL_W-1:0]  oth1;
  logic [LEVEL_W-1:0]  oth2;
  logic                is_rb;
  logic                is_green;
  logic                cls_done;
  logic                hit_now;
  logic [CW-1:0]       count_next;
  logic [SW-1:0]       sum_next;
  logic [CW:0]         trial;
  logic                found;
  logic [NW+CENTROID_W-1:0] quo_ext;
  logic [CW+MATCH_W-1:0]    count_ext;

  ctdc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  assign neg      = alu_y[DW-1];
  assign is_green = (target_colour == COLOUR_GREEN);
  assign is_rb    = (target_colour == COLOUR_RED) || (target_colour == COLOUR_BLUE);
  assign tgt      = (target_colour == COLOUR_BLUE) ? blue : red;
  assign oth1     = (target_colour == COLOUR_BLUE) ? red : green;
  assign oth2     = (target_colour == COLOUR_BLUE) ? green : blue;
  assign trial    = {rem, quo[NW-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state)
      ST_CLS: begin
        if (is_green) begin
          case (step)
            STEP_DIFF1: begin
              alu_a   = DW'(red);
              alu_b   = DW'(green);
              alu_sub = 1'b0;
            end
            STEP_LOW1: begin
              alu_a   = acc;
              alu_b   = DW'(blue);
              alu_sub = 1'b0;
            end
            default: begin
              // sum minus three times the limit
              alu_a = acc;
              alu_b = DW'(dark_limit);
            end
          endcase
        end else begin
          case (step)
            STEP_DIFF1: begin
              alu_a = DW'(tgt);
              alu_b = DW'(oth1);
            end
            STEP_DIFF2: begin
              alu_a = DW'(tgt);
              alu_b = DW'(oth2);
            end
            STEP_LOW1, STEP_LOW2: begin
              alu_a = DW'(relative_low);
              alu_b = DW'(diff);
            end
            default: begin
              alu_a = DW'(diff);
              alu_b = DW'(relative_high);
            end
          endcase
        end
      end
      ST_DIV: begin
        alu_a = DW'(trial);
        alu_b = DW'(hit_count);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    cls_done = 1'b1;
    hit_now  = 1'b0;
    if (is_green) begin
      cls_done = (step == STEP_LOW2);
      hit_now  = neg;
    end else if (is_rb) begin
      cls_done = (step == STEP_HIGH2);
      hit_now  = ok & neg;
    end
  end

  assign count_next = hit_count + CW'(1);
  assign sum_next   = index_sum + SW'(sensor_index);
  assign found      = last && (hit_count != '0);
  assign quo_ext    = {{CENTROID_W{1'b0}}, quo};
  assign count_ext  = {{MATCH_W{1'b0}}, hit_count};

  assign reading.ready = (state == ST_IDLE);
  assign result.valid  = out_valid;
  assign result.data   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      out_valid     <= 1'b0;
      sensor_index  <= '0;
      index_sum     <= '0;
      hit_count     <= '0;
      target_colour <= TARGET_COLOUR_RESET;
      relative_low  <= RELATIVE_LOW_RESET;
      relative_high <= RELATIVE_HIGH_RESET;
      dark_limit    <= DARK_LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_COLOUR: target_colour <= cfg_data[COLOUR_W-1:0];
          REG_RELATIVE_LOW:  relative_low  <= cfg_data[LEVEL_W-1:0];
          REG_RELATIVE_HIGH: relative_high <= cfg_data[LEVEL_W-1:0];
          REG_DARK_LIMIT:    dark_limit    <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && result.ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (reading.valid) begin
            red   <= reading.data.red_level;
            green <= reading.data.green_level;
            blue  <= reading.data.blue_level;
            last  <= reading.data.row_end || (sensor_index == LAST_INDEX);
            ok    <= 1'b1;
            step  <= '0;
            state <= ST_CLS;
          end
        end
        ST_CLS: begin
          acc <= alu_y;
          if (step == STEP_DIFF1 || step == STEP_DIFF2) begin
            diff <= alu_y[LEVEL_W-1:0];
          end
          if (step == STEP_LOW1 || step == STEP_HIGH1 || step == STEP_LOW2) begin
            ok <= ok & neg;
          end
          if (cls_done) begin
            hit <= hit_now;
            if (hit_now) begin
              hit_count <= count_next;
              index_sum <= sum_next;
            end
            if (last && (hit_now || hit_count != '0)) begin
              quo   <= {(hit_now ? sum_next : index_sum), {FRAC_W{1'b0}}};
              rem   <= '0;
              step  <= '0;
              state <= ST_DIV;
            end else begin
              state <= ST_FIN;
            end
          end else begin
            step <= step + STW'(1);
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          rem <= neg ? trial[CW-1:0] : alu_y[CW-1:0];
          quo <= {quo[NW-2:0], ~neg};
          if (step == STEP_DIV_LAST) begin
            state <= ST_FIN;
          end else begin
            step <= step + STW'(1);
          end
        end
        ST_FIN: begin
          if (!out_valid || result.ready) begin
            out_data.detected    <= hit;
            out_data.match_count <= count_ext[MATCH_W-1:0];
            out_data.centroid    <= found ? quo_ext[CENTROID_W-1:0] : '0;
            out_data.found       <= found;
            out_data.row_done    <= last;
            out_valid            <= 1'b1;
            if (last) begin
              sensor_index <= '0;
              index_sum    <= '0;
              hit_count    <= '0;
            end else begin
              sensor_index <= sensor_index + IW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_within_row: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, hit_count} <= {1'b0, sensor_index} + 1))
    else $error("match count exceeds readings in row");

  a_sum_zero_without_hits: assert property (@(posedge clk) disable iff (rst)
    (hit_count == '0) |-> (index_sum == '0))
    else $error("index sum nonzero with no matches");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FIN))
    else $error("result raised outside finish step");

  a_open_row_no_centroid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.row_done) |-> (!out_data.found && out_data.centroid == '0))
    else $error("centroid reported on open row");

  a_row_closes_at_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && sensor_index == LAST_INDEX) |-> last)
    else $error("last sensor did not close the row");

endmodule

`default_nettype wire
